>>> rtl/rgb_pixel_format_converter_unit_defines.svh
// assertion macros used by the converter unit
`ifndef RGB_PIXEL_FORMAT_CONVERTER_UNIT_DEFINES_SVH
`define RGB_PIXEL_FORMAT_CONVERTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define RGBPFC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked during reset as well
`define RGBPFC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGBPFC_ASSERT(name, prop, msg)
`define RGBPFC_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

>>> rtl/rgbpfc_pkg.sv
package rgbpfc_pkg;

  localparam int PIXEL_W     = 32;
  localparam int CHAN_W      = 8;
  localparam int PROD_W      = 2 * CHAN_W;
  localparam int FMT_W       = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // pixel format codes, codes 5 to 7 are unknown
  typedef enum logic [FMT_W-1:0] {
    FMT_RGB555 = 3'd0,
    FMT_RGB565 = 3'd1,
    FMT_BYTES3 = 3'd2,
    FMT_BYTES4 = 3'd3,
    FMT_RGBA   = 3'd4
  } fmt_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_FORMAT  = 3'd0,
    REG_DEST_FORMAT    = 3'd1,
    REG_SWAP_RED_BLUE  = 3'd2,
    REG_BACKDROP_RED   = 3'd3,
    REG_BACKDROP_GREEN = 3'd4,
    REG_BACKDROP_BLUE  = 3'd5
  } reg_index_t;

  // three 8-bit channels, c0 is red side, c2 blue side
  typedef struct packed {
    logic [CHAN_W-1:0] c0;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c2;
  } chan_t;

  // unpack a source pixel, short fields widened with zero low bits
  function automatic chan_t unpack(input logic [FMT_W-1:0] fmt,
                                   input logic [PIXEL_W-1:0] p);
    chan_t ch;
    ch = '0;
    case (fmt)
      FMT_RGB555: begin
        ch.c0 = {p[14:10], 3'b000};
        ch.c1 = {p[9:5], 3'b000};
        ch.c2 = {p[4:0], 3'b000};
      end
      FMT_RGB565: begin
        ch.c0 = {p[15:11], 3'b000};
        ch.c1 = {p[10:5], 2'b00};
        ch.c2 = {p[4:0], 3'b000};
      end
      FMT_BYTES3, FMT_BYTES4, FMT_RGBA: begin
        ch.c0 = p[7:0];
        ch.c1 = p[15:8];
        ch.c2 = p[23:16];
      end
      default: ch = '0;
    endcase
    return ch;
  endfunction

  // repack channels by truncation
  function automatic logic [PIXEL_W-1:0] pack(input logic [FMT_W-1:0] fmt,
                                              input chan_t ch);
    logic [PIXEL_W-1:0] r;
    r = '0;
    case (fmt)
      FMT_RGB555: r = {17'd0, ch.c0[7:3], ch.c1[7:3], ch.c2[7:3]};
      FMT_RGB565: r = {16'd0, ch.c0[7:3], ch.c1[7:2], ch.c2[7:3]};
      FMT_BYTES3, FMT_BYTES4: r = {8'h00, ch.c2, ch.c1, ch.c0};
      FMT_RGBA: r = {8'hff, ch.c2, ch.c1, ch.c0};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/rgbpfc_source_if.sv
interface rgbpfc_source_if;
  logic                             valid;
  logic                             ready;
  logic [rgbpfc_pkg::PIXEL_W-1:0]   source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

>>> rtl/rgbpfc_dest_if.sv
interface rgbpfc_dest_if;
  logic                             valid;
  logic                             ready;
  logic [rgbpfc_pkg::PIXEL_W-1:0]   dest_pixel;

  modport source (output valid, output dest_pixel, input ready);
  modport sink   (input valid, input dest_pixel, output ready);
endinterface

>>> rtl/rgb_pixel_format_converter_unit.sv
// Packed RGB pixel format converter.
// src carries one packed source pixel per request, dst one packed result
// pixel per request; both use valid/ready and a request moves when both
// are high at a rising clock edge.
// The cfg port writes format, red/blue swap and background registers:
// cfg_data lands in register cfg_index at an edge with cfg_wr_en high.
// Write it only while no pixel is in flight.
// Two register stages: input pixel and packed result. Unpack, alpha blend
// (rgba source only, three 8x8 multiply pairs), swap and repack sit between them.
// A pixel accepted into the input register moves into the result register
// once that register is free and is offered on dst from then on.
// One pixel per clock is sustained while dst is ready.
// Reset (rst, synchronous) empties both stages and clears every configuration
// register to zero: rgb555 in, rgb555 out, no swap, black background.
// When dst stalls, the result holds, the input register fills behind it,
// and src.ready drops only once both are occupied.
`include "rgb_pixel_format_converter_unit_defines.svh"

module rgb_pixel_format_converter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  rgbpfc_source_if.sink                        src,
  rgbpfc_dest_if.source                        dst,
  input  logic                                 cfg_wr_en,
  input  logic [rgbpfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rgbpfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic [rgbpfc_pkg::FMT_W-1:0]      source_format;
  logic [rgbpfc_pkg::FMT_W-1:0]      dest_format;
  logic                              swap_red_blue;
  logic [rgbpfc_pkg::CFG_DATA_W-1:0] backdrop_red;
  logic [rgbpfc_pkg::CFG_DATA_W-1:0] backdrop_green;
  logic [rgbpfc_pkg::CFG_DATA_W-1:0] backdrop_blue;

  // pipeline registers
  logic                              s1_valid;
  logic [rgbpfc_pkg::PIXEL_W-1:0]    s1_pixel;
  logic                              out_valid;
  logic [rgbpfc_pkg::PIXEL_W-1:0]    out_pixel;

  // stage handshakes
  logic out_ready, s1_ready;
  logic s1_load, out_load;

  // conversion logic
  rgbpfc_pkg::chan_t                 unpacked;
  logic [rgbpfc_pkg::CHAN_W-1:0]     alpha, alpha_inv;
  logic [rgbpfc_pkg::PROD_W-1:0]     fg0, fg1, fg2;
  logic [rgbpfc_pkg::PROD_W-1:0]     bg0, bg1, bg2;
  logic [rgbpfc_pkg::PROD_W:0]       sum0, sum1, sum2;
  rgbpfc_pkg::chan_t                 blended, swapped;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format  <= '0;
      dest_format    <= '0;
      swap_red_blue  <= 1'b0;
      backdrop_red   <= '0;
      backdrop_green <= '0;
      backdrop_blue  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rgbpfc_pkg::REG_SOURCE_FORMAT:  source_format  <= cfg_data[rgbpfc_pkg::FMT_W-1:0];
        rgbpfc_pkg::REG_DEST_FORMAT:    dest_format    <= cfg_data[rgbpfc_pkg::FMT_W-1:0];
        rgbpfc_pkg::REG_SWAP_RED_BLUE:  swap_red_blue  <= cfg_data[0];
        rgbpfc_pkg::REG_BACKDROP_RED:   backdrop_red   <= cfg_data;
        rgbpfc_pkg::REG_BACKDROP_GREEN: backdrop_green <= cfg_data;
        rgbpfc_pkg::REG_BACKDROP_BLUE:  backdrop_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-stage flow control, a stage loads when it is empty or draining
  assign out_ready = !out_valid || dst.ready;
  assign s1_ready  = !s1_valid || out_ready;
  assign s1_load   = src.valid && s1_ready;
  assign out_load  = s1_valid && out_ready;
  assign src.ready = s1_ready;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid  <= src.valid;
      if (out_ready) out_valid <= s1_valid;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pixel <= src.source_pixel;
    end
  end

  // unpack, blend, swap
  always_comb begin
    unpacked  = rgbpfc_pkg::unpack(source_format, s1_pixel);
    alpha     = s1_pixel[31:24];
    alpha_inv = 8'hff - alpha;
    fg0 = {{rgbpfc_pkg::CHAN_W{1'b0}}, alpha} * {{rgbpfc_pkg::CHAN_W{1'b0}}, unpacked.c0};
    fg1 = {{rgbpfc_pkg::CHAN_W{1'b0}}, alpha} * {{rgbpfc_pkg::CHAN_W{1'b0}}, unpacked.c1};
    fg2 = {{rgbpfc_pkg::CHAN_W{1'b0}}, alpha} * {{rgbpfc_pkg::CHAN_W{1'b0}}, unpacked.c2};
    bg0 = {{rgbpfc_pkg::CHAN_W{1'b0}}, alpha_inv} *
          {{rgbpfc_pkg::CHAN_W{1'b0}}, backdrop_red[15:8]};
    bg1 = {{rgbpfc_pkg::CHAN_W{1'b0}}, alpha_inv} *
          {{rgbpfc_pkg::CHAN_W{1'b0}}, backdrop_green[15:8]};
    bg2 = {{rgbpfc_pkg::CHAN_W{1'b0}}, alpha_inv} *
          {{rgbpfc_pkg::CHAN_W{1'b0}}, backdrop_blue[15:8]};
    sum0 = {1'b0, fg0} + {1'b0, bg0};
    sum1 = {1'b0, fg1} + {1'b0, bg1};
    sum2 = {1'b0, fg2} + {1'b0, bg2};
    if (source_format == rgbpfc_pkg::FMT_RGBA) begin
      blended.c0 = sum0[15:8];
      blended.c1 = sum1[15:8];
      blended.c2 = sum2[15:8];
    end else begin
      blended = unpacked;
    end
    swapped = blended;
    if (swap_red_blue) begin
      swapped.c0 = blended.c2;
      swapped.c2 = blended.c0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel <= rgbpfc_pkg::pack(dest_format, swapped);
    end
  end

  assign dst.valid      = out_valid;
  assign dst.dest_pixel = out_pixel;

  // checks
  `RGBPFC_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !dst.valid && !s1_valid,
    "pipeline not empty after reset")
  `RGBPFC_ASSERT(a_accept_fills_s1, src.valid && src.ready |=> s1_valid,
    "accepted request did not reach input register")
  `RGBPFC_ASSERT(a_s1_holds, s1_valid && !out_ready |=> s1_valid && $stable(s1_pixel),
    "stalled input register lost its pixel")
  `RGBPFC_ASSERT(a_out_holds, dst.valid && !dst.ready |=> dst.valid && $stable(dst.dest_pixel),
    "stalled result changed")
  `RGBPFC_ASSERT(a_full_when_blocked, !src.ready |-> s1_valid && dst.valid,
    "input blocked with an empty stage")

endmodule
